[hdl/hpnm_pkg.sv]
// hpnm_pkg: shared types and constants for the hsv palette nearest-match search
// used by hpnm_cell and hsv_palette_nearest_match
`timescale 1ns / 1ps

package hpnm_pkg;

    localparam int COLOR_COUNT_DEF = 256;
    // wide enough for any palette position up to 1024 entries
    localparam int IDX_W  = 10;
    localparam int DIST_W = 20;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [7:0] DARK_INIT = 8'd255;

    typedef struct packed {
        logic       en;
        logic [7:0] idx;
        logic [8:0] hue;
        logic [7:0] sat;
        logic [7:0] val;
    } load_t;

    typedef struct packed {
        logic [8:0]        hue;
        logic [7:0]        sat;
        logic [7:0]        val;
        logic              nz;
        logic [DIST_W-1:0] best;
        logic [IDX_W-1:0]  bidx;
        logic [7:0]        bval;
        logic              done;
        logic [7:0]        dark;
        logic [IDX_W-1:0]  gidx;
        logic              grey;
    } tok_t;

endpackage

[hdl/hpnm_cell.sv]
// hpnm_cell: one palette entry plus one search step of the query token
// depends on hpnm_pkg
`timescale 1ns / 1ps

module hpnm_cell
    import hpnm_pkg::*;
#(
    parameter int INDEX = 1
)
(
    input  logic clk,
    input  logic rst_n,
    input  load_t ld,
    input  tok_t  tin,
    input  logic  vin,
    output tok_t  tout,
    output logic  vout
);

    logic [8:0] ent_hue_reg;
    logic [7:0] ent_sat_reg;
    logic [7:0] ent_val_reg;

    logic signed [10:0] eh;
    logic signed [10:0] qh;
    logic signed [10:0] diff;
    logic signed [10:0] dh;
    logic signed [8:0]  ds;
    logic signed [8:0]  dv;
    logic signed [21:0] dh_sq;
    logic signed [17:0] ds_sq;
    logic signed [17:0] dv_sq;
    logic [DIST_W-1:0]  score;
    logic               take;
    tok_t               tok_next;
    tok_t               tok_reg;
    logic               vout_reg;

    always_ff @(posedge clk)
    begin
        if (ld.en && (IDX_W'(ld.idx) == IDX_W'(INDEX)))
        begin
            ent_hue_reg <= ld.hue;
            ent_sat_reg <= ld.sat;
            ent_val_reg <= ld.val;
        end
    end

    always_comb
    begin
        eh   = $signed({2'b00, ent_hue_reg});
        qh   = $signed({2'b00, tin.hue});
        diff = eh - qh;
        dh   = diff;
        if (diff > 11'sd180)
        begin
            dh = qh + 11'sd360 - eh;
        end
        else if (diff < -11'sd180)
        begin
            dh = eh + 11'sd360 - qh;
        end
        // low saturation makes hue meaningless
        if (tin.sat <= 8'd2)
        begin
            dh = '0;
        end
        ds    = $signed({1'b0, ent_sat_reg}) - $signed({1'b0, tin.sat});
        dv    = $signed({1'b0, ent_val_reg}) - $signed({1'b0, tin.val});
        dh_sq = dh * dh;
        ds_sq = ds * ds;
        dv_sq = dv * dv;
        score = {1'b0, dh_sq[17:0], 1'b0} + DIST_W'(ds_sq[15:0]) + DIST_W'(dv_sq[15:0]);

        tok_next = tin;
        take     = !tin.done && (score < tin.best);
        if (take)
        begin
            tok_next.best = score;
            tok_next.bidx = IDX_W'(INDEX - 1);
            tok_next.bval = ent_val_reg;
            tok_next.done = (score == '0);
        end
        // exact match ends the scan before the grey check
        if (!tin.done && !(take && score == '0) && ent_sat_reg == 8'd0
            && ent_val_reg != 8'd0 && ent_val_reg < tin.dark)
        begin
            tok_next.dark = ent_val_reg;
            tok_next.gidx = IDX_W'(INDEX - 1);
            tok_next.grey = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg <= tok_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vout_reg <= 1'b0;
        end
        else
        begin
            vout_reg <= vin;
        end
    end

    assign tout = tok_reg;
    assign vout = vout_reg;

endmodule

[hdl/hsv_palette_nearest_match.sv]
// hsv_palette_nearest_match: top level, a chain of hpnm_cell stages
// depends on hpnm_pkg and hpnm_cell
`timescale 1ns / 1ps

// Each palette entry 1..COLOR_COUNT-1 lives in its own cell; a query travels
// down the chain one cell per cycle carrying the best match and darkest grey so
// far. A load writes the entry registers of the addressed cell. A query passes
// through every cell of the chain, then the grey fixup into the result register,
// then the output register. One request is handled at a time, but a new
// request is taken while the previous result waits at the output register.
module hsv_palette_nearest_match
    import hpnm_pkg::*;
#(
    parameter int COLOR_COUNT = COLOR_COUNT_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       operation,
    input  logic [7:0] entry_index,
    input  logic [8:0] hue,
    input  logic [7:0] saturation,
    input  logic [7:0] brightness,
    input  logic       color_nonzero,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] match_index
);

    localparam int CELLS = COLOR_COUNT - 1;

    logic  accept;
    load_t ld;
    tok_t  tok_in;
    tok_t  chain_tok [CELLS+1];
    logic  chain_v   [CELLS+1];

    logic             busy_reg;
    logic             busy_next;
    logic             res_valid_reg;
    logic             res_valid_next;
    logic [IDX_W-1:0] res_idx_reg;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [7:0]       match_reg;
    tok_t             fin;
    logic [IDX_W-1:0] fin_idx;

    assign in_ready = !busy_reg;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        ld.en  = accept && (operation == OP_LOAD);
        ld.idx = entry_index;
        ld.hue = hue;
        ld.sat = saturation;
        ld.val = brightness;

        tok_in      = '0;
        tok_in.hue  = hue;
        tok_in.sat  = saturation;
        tok_in.val  = brightness;
        tok_in.nz   = color_nonzero;
        tok_in.best = '1;
        tok_in.dark = DARK_INIT;
    end

    assign chain_tok[0] = tok_in;
    assign chain_v[0]   = accept && (operation == OP_QUERY);

    for (genvar k = 0; k < CELLS; k++)
    begin : g_cell
        hpnm_cell #(
            .INDEX (k + 1)
        ) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .ld    (ld),
            .tin   (chain_tok[k]),
            .vin   (chain_v[k]),
            .tout  (chain_tok[k+1]),
            .vout  (chain_v[k+1])
        );
    end

    // black best match for a non-black query falls back to darkest grey
    always_comb
    begin
        fin     = chain_tok[CELLS];
        fin_idx = fin.bidx;
        if (fin.bval == 8'd0 && fin.nz && fin.grey)
        begin
            fin_idx = fin.gidx;
        end
    end

    always_ff @(posedge clk)
    begin
        if (chain_v[CELLS])
        begin
            res_idx_reg <= fin_idx;
        end
        if (res_valid_reg && (!out_valid_reg || out_ready))
        begin
            match_reg <= 8'(32'(res_idx_reg));
        end
    end

    always_comb
    begin
        busy_next      = busy_reg;
        res_valid_next = res_valid_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (res_valid_reg && (!out_valid_reg || out_ready))
        begin
            out_valid_next = 1'b1;
            res_valid_next = 1'b0;
            busy_next      = 1'b0;
        end
        if (chain_v[CELLS])
        begin
            res_valid_next = 1'b1;
        end
        if (accept && operation == OP_QUERY)
        begin
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            res_valid_reg <= res_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign match_index = match_reg;

endmodule
